// File: rtl/core/shp_pkg.sv
// Shared types and constants of the 3x3 line-buffered sharpen filter.
`timescale 1ns / 1ps
`default_nettype none

package shp_pkg;

	// Input opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// Configuration reset values
	localparam logic [7:0] AMOUNT_RST = 8'd16;
	localparam logic [11:0] FRAME_WIDTH_RST = 12'd1920;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} shp_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_end;
		logic       last_of_item;
	} shp_out_t;

	typedef struct packed {
		logic [7:0]  amount;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
	} cfg_t;

	typedef enum logic {
		CMD_PIXEL,
		CMD_DRAIN
	} cmd_kind_t;

	// Per-item control decided by the front
	typedef struct packed {
		cmd_kind_t kind;
		logic      first;   // column zero: reload the window
		logic      emit_a;  // result after the window update
		logic      last_a;
		logic      fe_a;
		logic      emit_b;  // second result after an extra shift (row end)
		logic      one_row; // frame of a single row
	} cmd_flags_t;

	// Queue entry: flags plus the new right-hand window column
	typedef struct packed {
		cmd_flags_t flags;
		pix_t       top;
		pix_t       mid;
		pix_t       bot;
	} shp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/shp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module shp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read in the same cycle; a read of the address being written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/shp_front.sv
// Front end: accepts items, tracks frame position, runs the line store, builds commands.
`timescale 1ns / 1ps
`default_nettype none

module shp_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire shp_pkg::shp_in_t      in_data,
	input  wire shp_pkg::cfg_t         cfg,
	input  wire logic                  restart,
	input  wire shp_pkg::queue_stat_t  q_stat,
	output logic                       q_push,
	output shp_pkg::shp_cmd_t          q_data
);
	import shp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int EWW = (WW > 12) ? WW : 12;
	localparam int EHW = (HW > 12) ? HW : 12;

	logic [WW-1:0]  w;
	logic [HW-1:0]  h;
	logic [EWW-1:0] fw_ext;
	logic [EHW-1:0] fh_ext;

	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] drain_col_q;
	logic          draining_q;
	logic          sel_q;

	logic          is_drain;
	logic          ignore;
	logic          accept;
	logic          take;
	logic [CW-1:0] col_pix;
	logic [CW-1:0] col_drn;
	logic          col_last;
	logic          drn_last;
	logic [CW-1:0] drn_rd;
	logic          row_last;
	logic          row_nz;
	logic [CW-1:0] rd_addr;
	pix_t          pix_in;
	cmd_flags_t    flags_d;
	logic          use_l1_d;

	logic          v_s1;
	cmd_flags_t    flags_s1;
	logic          use_l1_s1;
	logic          sel_s1;
	pix_t          pix_s1;

	logic          we0;
	logic          we1;
	logic [31:0]   rd0;
	logic [31:0]   rd1;
	pix_t          l1;
	pix_t          l2;

	// Clamp the configured frame size to the supported range
	always_comb begin
		fw_ext = EWW'(cfg.frame_width);
		fh_ext = EHW'(cfg.frame_height);
		if (fw_ext == '0) begin
			w = WW'(1);
		end else if (fw_ext > EWW'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(fw_ext);
		end
		if (fh_ext == '0) begin
			h = HW'(1);
		end else if (fh_ext > EHW'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(fh_ext);
		end
	end

	// Classify the item and work out its position
	always_comb begin
		is_drain = (in_data.opcode == OP_DRAIN);
		ignore   = is_drain ? !draining_q : draining_q;
		accept   = in_valid && in_ready;
		take     = accept && !ignore;
		col_pix  = (WW'(in_col_q) < w) ? in_col_q : CW'(w - WW'(1));
		col_drn  = (WW'(drain_col_q) < w) ? drain_col_q : CW'(w - WW'(1));
		col_last = (WW'(col_pix) + WW'(1)) >= w;
		drn_last = (WW'(col_drn) + WW'(1)) >= w;
		drn_rd   = drn_last ? col_drn : CW'(col_drn + CW'(1));
		row_last = (HW'(in_row_q) + HW'(1)) >= h;
		row_nz   = (in_row_q != '0);
		rd_addr  = is_drain ? drn_rd : col_pix;
		pix_in   = '{alpha: in_data.in_alpha, blue: in_data.in_blue,
			green: in_data.in_green, red: in_data.in_red};
	end

	// Decide which results the item will cause
	always_comb begin
		flags_d.one_row = (h == HW'(1));
		if (is_drain) begin
			flags_d.kind   = CMD_DRAIN;
			flags_d.first  = (col_drn == '0);
			flags_d.emit_a = 1'b1;
			flags_d.last_a = 1'b1;
			flags_d.fe_a   = drn_last;
			flags_d.emit_b = 1'b0;
			use_l1_d       = flags_d.one_row;
		end else begin
			flags_d.kind   = CMD_PIXEL;
			flags_d.first  = (col_pix == '0);
			flags_d.emit_a = row_nz && ((col_pix != '0) || col_last);
			flags_d.last_a = (col_pix == '0) || !col_last;
			flags_d.fe_a   = 1'b0;
			flags_d.emit_b = row_nz && (col_pix != '0) && col_last;
			use_l1_d       = HW'(in_row_q) < HW'(2);
		end
	end

	// Advance position counters and swap line roles at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			drain_col_q <= '0;
			draining_q  <= 1'b0;
			sel_q       <= 1'b0;
		end else if (restart) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			drain_col_q <= '0;
			draining_q  <= 1'b0;
		end else if (take) begin
			if (is_drain) begin
				if (drn_last) begin
					in_col_q    <= '0;
					in_row_q    <= '0;
					drain_col_q <= '0;
					draining_q  <= 1'b0;
				end else begin
					drain_col_q <= CW'(col_drn + CW'(1));
				end
			end else if (col_last) begin
				in_col_q <= '0;
				sel_q    <= !sel_q;
				if (row_last) begin
					in_row_q    <= '0;
					drain_col_q <= '0;
					draining_q  <= 1'b1;
				end else begin
					in_row_q <= RW'(in_row_q + RW'(1));
				end
			end else begin
				in_col_q <= CW'(col_pix + CW'(1));
			end
		end
	end

	// Pixel goes into the line holding the row before last; the other holds the last row
	assign we0 = take && !is_drain && sel_q;
	assign we1 = take && !is_drain && !sel_q;

	shp_ram #(
		.WIDTH(32),
		.DEPTH(MAX_WIDTH)
	) u_line0 (
		.clk   (clk),
		.we    (we0),
		.waddr (col_pix),
		.wdata (pix_in),
		.re    (take),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	shp_ram #(
		.WIDTH(32),
		.DEPTH(MAX_WIDTH)
	) u_line1 (
		.clk   (clk),
		.we    (we1),
		.waddr (col_pix),
		.wdata (pix_in),
		.re    (take),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	// Hold the command while the line store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flags_s1  <= flags_d;
			use_l1_s1 <= use_l1_d;
			sel_s1    <= sel_q;
			pix_s1    <= pix_in;
		end
	end

	// Assemble the new window column and push it
	always_comb begin
		l1              = sel_s1 ? pix_t'(rd1) : pix_t'(rd0);
		l2              = sel_s1 ? pix_t'(rd0) : pix_t'(rd1);
		q_data.flags    = flags_s1;
		q_data.top      = use_l1_s1 ? l1 : l2;
		q_data.mid      = l1;
		q_data.bot      = (flags_s1.kind == CMD_PIXEL) ? pix_s1 : l1;
	end

	assign q_push   = v_s1 && !q_stat.full;
	assign in_ready = !v_s1 || !q_stat.full;

endmodule

`default_nettype wire

// File: rtl/core/shp_queue.sv
// Short command queue between the front end and the filter back end.
`timescale 1ns / 1ps
`default_nettype none

module shp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire shp_pkg::shp_cmd_t     push_data,
	input  wire logic                  pop,
	output shp_pkg::shp_cmd_t          head,
	output shp_pkg::queue_stat_t       stat
);
	import shp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	shp_cmd_t      mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	// Store on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_q + AW'(1));
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_q + AW'(1));
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= NW'(cnt_q + NW'(1));
				2'b01:   cnt_q <= NW'(cnt_q - NW'(1));
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == NW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: rtl/core/shp_back.sv
// Back end: 3x3 window, sharpen arithmetic per channel and the output register.
`timescale 1ns / 1ps
`default_nettype none

module shp_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire shp_pkg::cfg_t         cfg,
	input  wire shp_pkg::queue_stat_t  q_stat,
	input  wire shp_pkg::shp_cmd_t     q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output shp_pkg::shp_out_t          out_data
);
	import shp_pkg::*;

	localparam int ACC_W = 22;

	function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] a);
		if (a[ACC_W-1]) begin
			return 8'd0;
		end else if (a[ACC_W-2:16] != '0) begin
			return 8'd255;
		end else begin
			return a[15:8];
		end
	endfunction

	logic adv;

	// Window rows top, middle, bottom; columns left, centre, right
	pix_t win_q [9];
	pix_t win_d [9];
	pix_t nv [3];
	pix_t lv [3];
	pix_t lat_top_q;
	pix_t lat_mid_q;
	logic pend_q;
	logic emit_d;
	logic last_d;
	logic fe_d;

	logic v_s1;
	logic last_s1;
	logic fe_s1;

	logic [7:0]        wch [9][3];
	logic [10:0]       nsum [3];
	logic signed [12:0] diff [3];

	logic               v_s2;
	logic               last_s2;
	logic               fe_s2;
	logic [7:0]         alpha_s2;
	logic [7:0]         cen_s2 [3];
	logic signed [12:0] diff_s2 [3];

	logic signed [ACC_W-1:0] prod [3];
	logic                    v_s3;
	logic                    last_s3;
	logic                    fe_s3;
	logic [7:0]              alpha_s3;
	logic signed [ACC_W-1:0] acc_s3 [3];

	logic     v_s4;
	shp_out_t out_s4;

	assign adv   = !v_s4 || out_ready;
	assign q_pop = adv && !pend_q && !q_stat.empty;

	assign nv[0] = q_head.top;
	assign nv[1] = q_head.mid;
	assign nv[2] = q_head.bot;
	assign lv[0] = lat_top_q;
	assign lv[1] = lat_mid_q;
	assign lv[2] = lat_mid_q;

	// Shift or reload the window for the next result
	always_comb begin
		win_d  = win_q;
		emit_d = 1'b0;
		last_d = 1'b0;
		fe_d   = 1'b0;
		if (pend_q) begin
			for (int j = 0; j < 3; j++) begin
				win_d[3*j]   = win_q[3*j+1];
				win_d[3*j+1] = win_q[3*j+2];
			end
			emit_d = 1'b1;
			last_d = 1'b1;
		end else if (!q_stat.empty) begin
			for (int j = 0; j < 3; j++) begin
				if (q_head.flags.first) begin
					win_d[3*j]   = (q_head.flags.kind == CMD_DRAIN) ? lv[j] : nv[j];
					win_d[3*j+1] = (q_head.flags.kind == CMD_DRAIN) ? lv[j] : nv[j];
				end else begin
					win_d[3*j]   = win_q[3*j+1];
					win_d[3*j+1] = win_q[3*j+2];
				end
				win_d[3*j+2] = nv[j];
			end
			emit_d = q_head.flags.emit_a;
			last_d = q_head.flags.last_a;
			fe_d   = q_head.flags.fe_a;
		end
	end

	// Window stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			v_s1   <= 1'b0;
		end else if (adv) begin
			pend_q <= q_pop && q_head.flags.emit_b;
			v_s1   <= emit_d;
		end
	end

	// Window payload; keep column zero of each row for the drain of the last row
	always_ff @(posedge clk) begin
		if (adv) begin
			win_q   <= win_d;
			last_s1 <= last_d;
			fe_s1   <= fe_d;
		end
		if (q_pop && q_head.flags.kind == CMD_PIXEL && q_head.flags.first) begin
			lat_top_q <= q_head.flags.one_row ? q_head.bot : q_head.mid;
			lat_mid_q <= q_head.bot;
		end
	end

	// Split window into channels
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			wch[k][0] = win_q[k].red;
			wch[k][1] = win_q[k].green;
			wch[k][2] = win_q[k].blue;
		end
	end

	// Neighbour sum and centre excess per channel
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			nsum[ch] = '0;
			for (int k = 0; k < 9; k++) begin
				if (k != 4) begin
					nsum[ch] = 11'(nsum[ch] + 11'(wch[k][ch]));
				end
			end
			diff[ch] = $signed({2'b00, wch[4][ch], 3'b000}) - $signed({2'b00, nsum[ch]});
		end
	end

	// Strength times excess
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = $signed({1'b0, cfg.amount}) * diff_s2[ch];
		end
	end

	// Arithmetic stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Arithmetic stage payload: sums, multiply-add, clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2  <= last_s1;
			fe_s2    <= fe_s1;
			alpha_s2 <= win_q[4].alpha;
			for (int ch = 0; ch < 3; ch++) begin
				cen_s2[ch]  <= wch[4][ch];
				diff_s2[ch] <= diff[ch];
			end

			last_s3  <= last_s2;
			fe_s3    <= fe_s2;
			alpha_s3 <= alpha_s2;
			for (int ch = 0; ch < 3; ch++) begin
				acc_s3[ch] <= $signed({6'b000000, cen_s2[ch], 8'h00})
					+ $signed(ACC_W'(128)) + prod[ch];
			end

			out_s4.out_red      <= clamp8(acc_s3[0]);
			out_s4.out_green    <= clamp8(acc_s3[1]);
			out_s4.out_blue     <= clamp8(acc_s3[2]);
			out_s4.out_alpha    <= alpha_s3;
			out_s4.frame_end    <= fe_s3;
			out_s4.last_of_item <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

endmodule

`default_nettype wire

// File: rtl/core/sharpen_3x3_line_buffered.sv
// Top level of the 3x3 line-buffered sharpen filter for RGBA pixel streams.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): pixels in raster order, opcode pixel,
//    then one drain transfer per pixel of the last row once the frame is in.
//  - out channel (out_valid/out_ready/out_data): sharpened pixels in raster order;
//    row y leaves during input row y+1, one pixel behind, the last row on drains.
//    A pixel transfer causes zero, one or two results (two at a row end).
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): 0 amount, 1 frame width,
//    2 frame height; always ready; width or height writes restart the frame.
// Throughput: one input transfer per cycle; the filter back end takes one command per
// cycle unless out_ready stalls it and pauses after a row end, so the command queue
// absorbs the first few row ends; once full, each further row end drops in_ready.
// Path from input transfer to result: line store read, queue, window, sum,
// multiply-add, clamp register.
// Reset: position counters clear and configuration returns to defaults; the line
// store needs no clearing. A stalled receiver holds the output register and the
// filter pipeline; the queue then fills and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module sharpen_3x3_line_buffered #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire shp_pkg::shp_in_t                   in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output shp_pkg::shp_out_t                       out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [shp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [shp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import shp_pkg::*;

	cfg_t        cfg_q;
	logic        restart;
	logic        q_push;
	logic        q_pop;
	shp_cmd_t    q_in;
	shp_cmd_t    q_head;
	queue_stat_t q_stat;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && ((cfg_index == REG_FRAME_WIDTH)
		|| (cfg_index == REG_FRAME_HEIGHT));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amount       <= AMOUNT_RST;
			cfg_q.frame_width  <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AMOUNT:       cfg_q.amount       <= cfg_data[7:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	shp_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.restart  (restart),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	shp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	shp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_stat.full)
		else $error("command pushed into full queue");

	// Back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_stat.empty)
		else $error("command popped from empty queue");

	// The final pixel of a frame is always the last result of its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.last_of_item)
		else $error("frame end without last-of-item");

endmodule

`default_nettype wire
